// File: rtl/rhht_pkg.sv
// Package for the Robin Hood hash table: sizes, mode and status codes.
// No dependencies; every rtl file imports it.
`timescale 1ns / 1ps
`default_nettype none
package rhht_pkg;
    localparam int TableSize = 1024;
    localparam int SlotW = $clog2(TableSize);
    localparam int CountW = SlotW + 1;
    localparam logic [63:0] MixMult = 64'hBEA225F9EB34556D;
    localparam logic [7:0] DistLimit = 8'hFF;

    localparam logic [1:0] ModeFind = 2'd0;
    localparam logic [1:0] ModeInsert = 2'd1;
    localparam logic [1:0] ModeRemove = 2'd2;
    localparam logic [1:0] ModeRead = 2'd3;

    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StAbsent = 2'd1;
    localparam logic [1:0] StLimit = 2'd2;
    localparam logic [1:0] StOverflow = 2'd3;

    localparam logic [0:0] RegMaxEntries = 1'd0;
endpackage
`default_nettype wire

// File: rtl/robin_hood_hash_table.sv
// Top level of the Robin Hood hash table: sequencer, slot memory, APB port.
// Depends on rhht_pkg and rhht_hash.
`timescale 1ns / 1ps
`default_nettype none
// The table holds up to 1024 entries, each a 32-bit key and a 32-bit value,
// with a probe distance byte per slot. It handles one item at a time:
// o_ready is low from acceptance until the result has been taken.
//
// After reset, a clearing pass zeroes the distance memory one slot per
// cycle; no item is accepted during the pass. APB writes still work
// during the pass.
//
// Steps per mode:
// - Read slot skips the hash: its slot is read, and the result is then
//   offered.
// - Every other mode first passes through the hash stage: a start step,
//   the partial products and a done step. The hash is three 64-bit
//   multiplies, each built from three 32x32 partial products on one
//   shared multiplier.
// - Each slot probed then takes a memory read, then a decision.
// - Insert of a new key scans the rest of the cluster, reading and
//   checking each occupied slot. It then moves each entry forward and
//   finally places the key.
// - Remove pulls each following entry back, reading and then writing
//   each one, and then clears the slot that ends the run.
//
// A find that hits at its home slot offers its result after the hash,
// one memory read and one decision. Long shifts scale with the run
// length.
//
// Because the scan comes first, a distance overflow or load-limit failure
// leaves the table unchanged. The result is held in output registers until
// o_valid and i_ready are both high at a clock edge.
module robin_hood_hash_table
    import rhht_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [1:0]        i_mode,
    input  wire logic [31:0]       i_key,
    input  wire logic [31:0]       i_value,
    input  wire logic [9:0]        i_slot,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [1:0]             o_status,
    output logic [31:0]            o_found_key,
    output logic [31:0]            o_found_value,
    output logic [9:0]             o_where,
    output logic [10:0]            o_entry_count
);
    typedef enum logic [10:0] {
        S_CLEAR  = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_HASH   = 11'b00000000100,
        S_PRD    = 11'b00000001000,   // probe: wait for read data
        S_PCHK   = 11'b00000010000,   // probe: decide
        S_SCAN   = 11'b00000100000,   // insert: scan cluster to its end
        S_SCHK   = 11'b00001000000,
        S_SHIFT  = 11'b00010000000,   // insert: move entry e-1 to e
        S_RMV    = 11'b00100000000,   // remove: look at the next slot
        S_RCHK   = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    // Slot memory: one write port, one registered read port.
    logic [31:0] r_kmem [TableSize];
    logic [31:0] r_vmem [TableSize];
    logic [7:0]  r_dmem [TableSize];
    logic [SlotW-1:0] w_raddr, w_waddr;
    logic        w_we, w_wkv;
    logic [31:0] w_wk, w_wv;
    logic [7:0]  w_wd;
    logic [31:0] r_rk, r_rv;
    logic [7:0]  r_rd;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_dmem[w_waddr] <= w_wd;
            if (w_wkv) begin
                r_kmem[w_waddr] <= w_wk;
                r_vmem[w_waddr] <= w_wv;
            end
        end
        r_rk <= r_kmem[w_raddr];
        r_rv <= r_vmem[w_raddr];
        r_rd <= r_dmem[w_raddr];
    end

    logic [1:0]  r_mode;
    logic [31:0] r_key, r_val;
    logic [SlotW-1:0] r_p, n_p, r_e, n_e;
    logic [7:0]  r_o, n_o;
    logic        r_over, n_over;
    logic [CountW-1:0] r_count, n_count, r_max;
    logic [1:0]  r_st, n_st;
    logic [31:0] r_fk, n_fk, r_fv, n_fv;
    logic [9:0]  r_wh, n_wh;
    logic        w_hstart, w_hdone;
    logic [SlotW-1:0] w_home;

    // After the last shift, S_SCHK must see slot p as empty; the read data is masked.
    logic r_force_empty;
    logic [7:0] w_rd_eff;
    assign w_rd_eff = r_force_empty ? 8'd0 : r_rd;

    rhht_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hstart),
        .i_key   (r_key),
        .o_done  (w_hdone),
        .o_home  (w_home)
    );

    assign pready = 1'b1;
    assign prdata = (paddr[2] == RegMaxEntries) ? {{(32-CountW){1'b0}}, r_max} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max <= CountW'(1024);
        else if (psel && penable && pwrite && paddr[2] == RegMaxEntries)
            r_max <= pwdata[CountW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mode <= i_mode; r_key <= i_key; r_val <= i_value;
        end
    end
    logic w_acc;
    assign w_acc = o_ready && i_valid;
    assign w_hstart = (r_state == S_HASH) && !r_over && r_o == 8'd0;

    always_comb begin
        n_state = r_state; n_p = r_p; n_e = r_e; n_o = r_o; n_over = r_over;
        n_count = r_count; n_st = r_st; n_fk = r_fk; n_fv = r_fv; n_wh = r_wh;
        w_raddr = r_p; w_waddr = r_p; w_we = 1'b0; w_wkv = 1'b0;
        w_wk = r_key; w_wv = r_val; w_wd = 8'd0;
        case (r_state)
            S_CLEAR: begin
                w_waddr = r_p; w_we = 1'b1; w_wd = 8'd0;
                n_p = r_p + 1'b1;
                if (r_p == SlotW'(TableSize - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_acc) begin
                    n_st = StAbsent; n_fk = '0; n_fv = '0; n_wh = '0;
                    n_over = 1'b0; n_o = 8'd0;
                    if (i_mode == ModeRead) begin
                        n_wh = i_slot; n_p = i_slot[SlotW-1:0];
                        n_state = S_PRD;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                // first cycle starts the unit (r_o==0), then marks busy
                n_o = 8'd1; n_over = 1'b1;
                if (w_hdone) begin
                    n_p = w_home; n_over = 1'b0; n_state = S_PRD;
                end
            end
            S_PRD: begin
                w_raddr = r_p; n_state = S_PCHK;
            end
            S_PCHK: begin
                if (r_mode == ModeRead) begin
                    if (r_rd != 8'd0) begin
                        n_st = StOk; n_fk = r_rk; n_fv = r_rv;
                    end
                    n_state = S_OUT;
                end else if (r_o < r_rd) begin
                    n_p = r_p + 1'b1; n_o = r_o + 8'd1; n_state = S_PRD;
                end else if (r_o == r_rd && r_rk != r_key) begin
                    n_p = r_p + 1'b1; n_o = r_o + 8'd1; n_state = S_PRD;
                end else if (r_o == r_rd) begin
                    // hit
                    n_st = StOk; n_fk = r_key; n_wh = 10'(r_p);
                    case (r_mode)
                        ModeFind: begin n_fv = r_rv; n_state = S_OUT; end
                        ModeInsert: begin
                            w_we = 1'b1; w_wkv = 1'b1; w_waddr = r_p;
                            w_wk = r_key; w_wv = r_val; w_wd = r_rd;
                            n_fv = r_val; n_state = S_OUT;
                        end
                        default: begin
                            n_fv = r_rv;
                            if (r_count != '0) n_count = r_count - 1'b1;
                            n_e = r_p; n_state = S_RMV;
                        end
                    endcase
                end else begin
                    // miss at slot p with distance o
                    if (r_mode == ModeInsert) begin
                        if (r_count >= r_max || r_count >= CountW'(TableSize)) begin
                            n_st = StLimit; n_state = S_OUT;
                        end else if (r_o >= DistLimit) begin
                            n_st = StOverflow; n_state = S_OUT;
                        end else begin
                            n_e = r_p; n_over = 1'b0; n_state = S_SCHK;
                        end
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_SCAN: begin
                w_raddr = r_e; n_state = S_SCHK;
            end
            S_SCHK: begin
                // w_rd_eff holds distance of slot r_e (first visit reuses probe read)
                if (w_rd_eff != 8'd0) begin
                    if (w_rd_eff + 8'd1 >= DistLimit) n_over = 1'b1;
                    n_e = r_e + 1'b1; n_state = S_SCAN;
                end else if (r_over) begin
                    n_st = StOverflow; n_state = S_OUT;
                end else begin
                    n_state = S_SHIFT;
                    w_raddr = r_e - 1'b1;
                    if (r_e == r_p) begin
                        w_we = 1'b1; w_wkv = 1'b1; w_waddr = r_p;
                        w_wk = r_key; w_wv = r_val; w_wd = r_o;
                        n_count = r_count + 1'b1;
                        n_st = StOk; n_fk = r_key; n_fv = r_val; n_wh = 10'(r_p);
                        n_state = S_OUT;
                    end
                end
            end
            S_SHIFT: begin
                // read data is slot e-1: move it to e
                w_we = 1'b1; w_wkv = 1'b1; w_waddr = r_e;
                w_wk = r_rk; w_wv = r_rv; w_wd = r_rd + 8'd1;
                n_e = r_e - 1'b1;
                w_raddr = r_e - 2'd2;
                if (r_e - 1'b1 == r_p) n_state = S_SCHK;
            end
            S_RMV: begin
                w_raddr = r_e + 1'b1; n_state = S_RCHK;
            end
            S_RCHK: begin
                if (r_rd <= 8'd1) begin
                    w_we = 1'b1; w_waddr = r_e; w_wd = 8'd0;
                    n_state = S_OUT;
                end else begin
                    w_we = 1'b1; w_wkv = 1'b1; w_waddr = r_e;
                    w_wk = r_rk; w_wv = r_rv; w_wd = r_rd - 8'd1;
                    n_e = r_e + 1'b1; n_state = S_RMV;
                end
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_p <= '0; r_count <= '0; r_force_empty <= 1'b0;
            r_o <= 8'd0; r_over <= 1'b0;
        end else begin
            r_state <= n_state; r_p <= n_p; r_count <= n_count; r_o <= n_o;
            r_over <= n_over;
            r_force_empty <= (r_state == S_SHIFT) && (n_state == S_SCHK);
        end
        r_e <= n_e; r_st <= n_st; r_fk <= n_fk; r_fv <= n_fv; r_wh <= n_wh;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_status = r_st;
    assign o_found_key = r_fk;
    assign o_found_value = r_fv;
    assign o_where = r_wh;
    assign o_entry_count = r_count;
endmodule
`default_nettype wire

// File: rtl/rhht_hash.sv
// Iterative home-slot hash: one 32x32 partial product per cycle, shared.
// Depends on rhht_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rhht_hash
    import rhht_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [31:0]      i_key,
    output logic                  o_done,
    output logic [SlotW-1:0]      o_home
);
    // Each 64x64 (low 64) multiply uses three partial products:
    // lo*lo (full 64), hi*lo and lo*hi (low 32 each).
    logic [63:0] r_h, n_h;
    logic [63:0] r_acc, n_acc;
    logic [1:0]  r_round, n_round;   // which multiply of three
    logic [1:0]  r_part, n_part;     // which partial product
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [31:0] w_a, w_b;
    logic [63:0] w_prod, w_mixed;

    always_comb begin
        case (r_part)
            2'd0: begin w_a = r_h[31:0]; w_b = MixMult[31:0]; end
            2'd1: begin w_a = r_h[63:32]; w_b = MixMult[31:0]; end
            default: begin w_a = r_h[31:0]; w_b = MixMult[63:32]; end
        endcase
        w_prod = {32'd0, w_a} * {32'd0, w_b};
    end

    always_comb begin
        n_h = r_h; n_acc = r_acc; n_round = r_round; n_part = r_part;
        n_busy = r_busy; n_done = 1'b0;
        w_mixed = '0;
        if (i_start) begin
            n_h = {32'd0, i_key};   // h ^= h >> 32 leaves a 32-bit key alone
            n_acc = '0; n_round = 2'd0; n_part = 2'd0; n_busy = 1'b1;
        end else if (r_busy) begin
            case (r_part)
                2'd0: begin n_acc = w_prod; n_part = 2'd1; end
                2'd1: begin
                    n_acc = {r_acc[63:32] + w_prod[31:0], r_acc[31:0]};
                    n_part = 2'd2;
                end
                default: begin
                    w_mixed = {r_acc[63:32] + w_prod[31:0], r_acc[31:0]};
                    if (r_round == 2'd1) w_mixed = w_mixed ^ (w_mixed >> 32);
                    else w_mixed = w_mixed ^ (w_mixed >> 29);
                    n_h = w_mixed; n_part = 2'd0;
                    if (r_round == 2'd2) begin
                        n_busy = 1'b0; n_done = 1'b1;
                    end else begin
                        n_round = r_round + 2'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
        r_h <= n_h; r_acc <= n_acc; r_round <= n_round; r_part <= n_part;
    end

    // (h[31:0] * TableSize) >> 32 keeps the top SlotW bits for a power of two.
    assign o_home = r_h[31 -: SlotW];
    assign o_done = r_done;
endmodule
`default_nettype wire
